// ----- design/rsi_pkg.sv -----
// Shared types, widths and constants for the ray/sphere intersection pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned RadW   = CoordW - 1;
  localparam int unsigned LimW   = 32;
  localparam int unsigned CfgW   = 32;

  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned AW     = ProdW;
  localparam int unsigned HW     = ProdW + 1;
  localparam int unsigned MagW   = ProdW;
  localparam int unsigned LimbW  = (MagW + 2) / 3;
  localparam int unsigned RowW   = 4 * LimbW;
  localparam int unsigned TotW   = 6 * LimbW;
  localparam int unsigned SqW    = TotW + 2;
  localparam int unsigned DiscW  = AW + 2 * RadW;
  localparam int unsigned RootW  = DiscW / 2;
  localparam int unsigned NumW   = MagW + 1;
  localparam int unsigned NumShW = NumW + FracW;
  localparam int unsigned QuoW   = CoordW - 1;
  localparam int unsigned CmpW   = AW + QuoW;

  localparam logic signed [CoordW-1:0] ParamMax = {1'b0, {(CoordW - 1){1'b1}}};
  localparam logic signed [CoordW-1:0] ParamMin = {1'b1, {(CoordW - 1){1'b0}}};

  typedef enum logic [0:0] {
    RegRadius = 1'b0,
    RegLimit  = 1'b1
  } reg_idx_e;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic                   miss;
    logic [AW-1:0]          a;
    logic signed [HW-1:0]   h;
    logic [DiscW-1:0]       disc;
  } quad_t;

  typedef struct packed {
    logic                   miss;
    logic [AW-1:0]          a;
    logic signed [HW-1:0]   h;
    logic [RootW-1:0]       root;
  } root_t;

  typedef struct packed {
    logic              neg;
    logic              sat;
    logic [NumShW-1:0] rem;
    logic [QuoW-1:0]   quo;
  } lane_t;

  typedef struct packed {
    logic          miss;
    logic [AW-1:0] a;
    lane_t [1:0]   lane;
  } div_t;

  typedef struct packed {
    logic   hit;
    coord_t far_p;
    coord_t near_p;
  } res_t;

endpackage

// ----- design/rsi_quad.sv -----
// Quadratic front end: differences, dot products, split wide products, discriminant.
// Depends on rsi_pkg. Seven register stages.
`timescale 1ns / 1ps
module rsi_quad (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  rsi_pkg::coord_t [2:0]      start_i,
  input  rsi_pkg::coord_t [2:0]      end_i,
  input  rsi_pkg::coord_t [2:0]      centre_i,
  input  logic [rsi_pkg::RadW-1:0]   radius_i,
  input  logic [rsi_pkg::LimW-1:0]   limit_i,
  output logic                       valid_o,
  output rsi_pkg::quad_t             quad_o
);
  import rsi_pkg::*;

  logic [6:0] vld_q;

  logic signed [DiffW-1:0] d_q [3];
  logic signed [DiffW-1:0] e_q [3];

  logic signed [ProdW-1:0] dd_q [3];
  logic signed [ProdW-1:0] de_q [3];
  logic signed [ProdW-1:0] ee_q [3];
  logic [2*RadW-1:0]       rr_q;

  logic [AW-1:0]        a3_q;
  logic signed [HW-1:0] h3_q;
  logic signed [HW-1:0] c3_q;

  logic [3*LimbW-1:0]   hx, cx, ax;
  logic [2*LimbW-1:0]   phh_d [3][3];
  logic [2*LimbW-1:0]   pac_d [3][3];
  logic [2*LimbW-1:0]   phh_q [3][3];
  logic [2*LimbW-1:0]   pac_q [3][3];
  logic [AW-1:0]        a4_q;
  logic signed [HW-1:0] h4_q;
  logic                 cneg4_q, miss4_q;

  logic [RowW-1:0]      rhh_d [3];
  logic [RowW-1:0]      rac_d [3];
  logic [RowW-1:0]      rhh_q [3];
  logic [RowW-1:0]      rac_q [3];
  logic [AW-1:0]        a5_q;
  logic signed [HW-1:0] h5_q;
  logic                 cneg5_q, miss5_q;

  logic [TotW-1:0]      hh_d, ac_d;
  logic [TotW-1:0]      hh_q, ac_q;
  logic [AW-1:0]        a6_q;
  logic signed [HW-1:0] h6_q;
  logic                 cneg6_q, miss6_q;

  logic [SqW-1:0]       disc;
  quad_t                quad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= DiffW'($signed(end_i[k])) - DiffW'($signed(start_i[k]));
        e_q[k] <= DiffW'($signed(start_i[k])) - DiffW'($signed(centre_i[k]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        dd_q[k] <= ProdW'(d_q[k]) * ProdW'(d_q[k]);
        de_q[k] <= ProdW'(d_q[k]) * ProdW'(e_q[k]);
        ee_q[k] <= ProdW'(e_q[k]) * ProdW'(e_q[k]);
      end
      rr_q <= (2*RadW)'(radius_i) * (2*RadW)'(radius_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a3_q <= AW'(dd_q[0]) + AW'(dd_q[1]) + AW'(dd_q[2]);
      h3_q <= HW'(de_q[0]) + HW'(de_q[1]) + HW'(de_q[2]);
      c3_q <= HW'(ee_q[0]) + HW'(ee_q[1]) + HW'(ee_q[2]) - HW'($signed({1'b0, rr_q}));
    end
  end

  always_comb begin
    hx = (3*LimbW)'(h3_q[HW-1] ? MagW'(-h3_q) : MagW'(h3_q));
    cx = (3*LimbW)'(c3_q[HW-1] ? MagW'(-c3_q) : MagW'(c3_q));
    ax = (3*LimbW)'(a3_q);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        phh_d[i][j] = (2*LimbW)'(hx[i*LimbW +: LimbW]) * (2*LimbW)'(hx[j*LimbW +: LimbW]);
        pac_d[i][j] = (2*LimbW)'(ax[i*LimbW +: LimbW]) * (2*LimbW)'(cx[j*LimbW +: LimbW]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phh_q   <= phh_d;
      pac_q   <= pac_d;
      a4_q    <= a3_q;
      h4_q    <= h3_q;
      cneg4_q <= c3_q[HW-1];
      miss4_q <= (a3_q == '0) || (a3_q < AW'(limit_i));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rhh_d[i] = '0;
      rac_d[i] = '0;
      for (int j = 0; j < 3; j++) begin
        rhh_d[i] = rhh_d[i] + (RowW'(phh_q[i][j]) << (j * LimbW));
        rac_d[i] = rac_d[i] + (RowW'(pac_q[i][j]) << (j * LimbW));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rhh_q   <= rhh_d;
      rac_q   <= rac_d;
      a5_q    <= a4_q;
      h5_q    <= h4_q;
      cneg5_q <= cneg4_q;
      miss5_q <= miss4_q;
    end
  end

  always_comb begin
    hh_d = '0;
    ac_d = '0;
    for (int i = 0; i < 3; i++) begin
      hh_d = hh_d + (TotW'(rhh_q[i]) << (i * LimbW));
      ac_d = ac_d + (TotW'(rac_q[i]) << (i * LimbW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q    <= hh_d;
      ac_q    <= ac_d;
      a6_q    <= a5_q;
      h6_q    <= h5_q;
      cneg6_q <= cneg5_q;
      miss6_q <= miss5_q;
    end
  end

  assign disc = cneg6_q ? SqW'(hh_q) + SqW'(ac_q) : SqW'(hh_q) - SqW'(ac_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q.miss <= miss6_q || disc[SqW-1];
      quad_q.a    <= a6_q;
      quad_q.h    <= h6_q;
      quad_q.disc <= disc[DiscW-1:0];
    end
  end

  assign valid_o = vld_q[6];
  assign quad_o  = quad_q;

endmodule

// ----- design/rsi_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on rsi_pkg; carries the miss flag, a and h alongside.
`timescale 1ns / 1ps
module rsi_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  rsi_pkg::quad_t quad_i,
  output logic           valid_o,
  output rsi_pkg::root_t root_o
);
  import rsi_pkg::*;

  logic [DiscW:0] rem_c [RootW];
  root_t          sd_c  [RootW];
  logic           vld_c [RootW];
  logic [DiscW:0] rem_q [RootW];
  root_t          sd_q  [RootW];
  logic           vld_q [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    localparam int unsigned B = RootW - 1 - s;
    logic [DiscW:0] trial;
    logic           take;
    root_t          sd_d;

    if (s == 0) begin : g_first
      assign rem_c[s]      = {1'b0, quad_i.disc};
      assign sd_c[s].miss  = quad_i.miss;
      assign sd_c[s].a     = quad_i.a;
      assign sd_c[s].h     = quad_i.h;
      assign sd_c[s].root  = '0;
      assign vld_c[s]      = valid_i;
    end else begin : g_next
      assign rem_c[s] = rem_q[s-1];
      assign sd_c[s]  = sd_q[s-1];
      assign vld_c[s] = vld_q[s-1];
    end

    assign trial = ((DiscW+1)'(sd_c[s].root) << (B + 1)) | ((DiscW+1)'(1) << (2 * B));
    assign take  = rem_c[s] >= trial;

    always_comb begin
      sd_d         = sd_c[s];
      sd_d.root[B] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_c[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? rem_c[s] - trial : rem_c[s];
        sd_q[s]  <= sd_d;
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = sd_q[RootW-1];

endmodule

// ----- design/rsi_div.sv -----
// Two-lane pipelined restoring divider for the far and near line parameters,
// with sign handling and saturation. Depends on rsi_pkg.
`timescale 1ns / 1ps
module rsi_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  rsi_pkg::root_t root_i,
  output logic           valid_o,
  output rsi_pkg::res_t  res_o
);
  import rsi_pkg::*;

  logic signed [NumW:0] hx, sx;
  logic signed [NumW:0] num [2];
  div_t                 nm_d, nm_q;
  logic                 nm_vld_q;
  div_t                 dv0_d;

  div_t                 dv_q   [QuoW+1];
  logic                 dv_vld [QuoW+1];

  res_t                 res_d, res_q;
  logic                 res_vld_q;

  assign hx     = (NumW+1)'($signed(root_i.h));
  assign sx     = (NumW+1)'($signed({1'b0, root_i.root}));
  assign num[0] = sx - hx;
  assign num[1] = -hx - sx;

  always_comb begin
    nm_d.miss = root_i.miss;
    nm_d.a    = root_i.a;
    for (int l = 0; l < 2; l++) begin
      nm_d.lane[l].neg = num[l][NumW];
      nm_d.lane[l].sat = 1'b0;
      nm_d.lane[l].rem = {(num[l][NumW] ? NumW'(-num[l]) : NumW'(num[l])), {FracW{1'b0}}};
      nm_d.lane[l].quo = '0;
    end
  end

  always_comb begin
    dv0_d = nm_q;
    for (int l = 0; l < 2; l++) begin
      dv0_d.lane[l].sat = CmpW'(nm_q.lane[l].rem) >= (CmpW'(nm_q.a) << QuoW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_vld_q  <= 1'b0;
      dv_vld[0] <= 1'b0;
      res_vld_q <= 1'b0;
    end else if (en_i) begin
      nm_vld_q  <= valid_i;
      dv_vld[0] <= nm_vld_q;
      res_vld_q <= dv_vld[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nm_q    <= nm_d;
      dv_q[0] <= dv0_d;
    end
  end

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    localparam int unsigned B = QuoW - 1 - s;
    logic [CmpW-1:0] trial;
    div_t            dv_d;

    assign trial = CmpW'(dv_q[s].a) << B;

    always_comb begin
      dv_d = dv_q[s];
      for (int l = 0; l < 2; l++) begin
        if (CmpW'(dv_q[s].lane[l].rem) >= trial) begin
          dv_d.lane[l].rem    = dv_q[s].lane[l].rem - trial[NumShW-1:0];
          dv_d.lane[l].quo[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld[s+1] <= 1'b0;
      end else if (en_i) begin
        dv_vld[s+1] <= dv_vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[s+1] <= dv_d;
      end
    end
  end

  function automatic coord_t lane_result(input logic miss, input lane_t ln);
    coord_t q;
    q = CoordW'({1'b0, ln.quo});
    if (miss) begin
      return '0;
    end else if (ln.sat) begin
      return ln.neg ? ParamMin : ParamMax;
    end else begin
      return ln.neg ? -q : q;
    end
  endfunction

  always_comb begin
    res_d.hit    = !dv_q[QuoW].miss;
    res_d.far_p  = lane_result(dv_q[QuoW].miss, dv_q[QuoW].lane[0]);
    res_d.near_p = lane_result(dv_q[QuoW].miss, dv_q[QuoW].lane[1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = res_vld_q;
  assign res_o   = res_q;

endmodule

// ----- design/ray_sphere_intersection_top.sv -----
// Top level of the ray/sphere intersection pipeline: config registers, stall
// control, and the quad, sqrt and divider sections. Depends on rsi_pkg.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   request  | in_valid_i / in_ready_o   | start_*_i, end_*_i, centre_*_i
//   result   | out_valid_o / out_ready_i | hit_o, far_param_o, near_param_o
//   config   | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One request per cycle, except while a stalled result holds in_ready_o low.
// The root's 64 result bits and the 31 quotient steps set the depth.
// Reset clears the stage valid bits and loads radius 1.0 and limit 1.
// A stalled result freezes every stage at once; in_ready_o drops only then.
`timescale 1ns / 1ps
module ray_sphere_intersection_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [rsi_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [rsi_pkg::CoordW-1:0] start_x_i,
  input  logic signed [rsi_pkg::CoordW-1:0] start_y_i,
  input  logic signed [rsi_pkg::CoordW-1:0] start_z_i,
  input  logic signed [rsi_pkg::CoordW-1:0] end_x_i,
  input  logic signed [rsi_pkg::CoordW-1:0] end_y_i,
  input  logic signed [rsi_pkg::CoordW-1:0] end_z_i,
  input  logic signed [rsi_pkg::CoordW-1:0] centre_x_i,
  input  logic signed [rsi_pkg::CoordW-1:0] centre_y_i,
  input  logic signed [rsi_pkg::CoordW-1:0] centre_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic signed [rsi_pkg::CoordW-1:0] far_param_o,
  output logic signed [rsi_pkg::CoordW-1:0] near_param_o
);
  import rsi_pkg::*;

  logic [RadW-1:0] radius_q;
  logic [LimW-1:0] limit_q;
  logic            en;
  coord_t [2:0]    start_v, end_v, centre_v;
  logic            quad_vld, root_vld, res_vld;
  quad_t           quad;
  root_t           root;
  res_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadW'(65536);
      limit_q  <= LimW'(1);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegRadius: radius_q <= cfg_data_i[RadW-1:0];
        RegLimit:  limit_q  <= cfg_data_i[LimW-1:0];
      endcase
    end
  end

  // advance when the result slot is free or being taken
  assign en         = out_ready_i || !res_vld;
  assign in_ready_o = en;

  assign start_v  = {start_z_i, start_y_i, start_x_i};
  assign end_v    = {end_z_i, end_y_i, end_x_i};
  assign centre_v = {centre_z_i, centre_y_i, centre_x_i};

  rsi_quad u_quad (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .start_i  (start_v),
    .end_i    (end_v),
    .centre_i (centre_v),
    .radius_i (radius_q),
    .limit_i  (limit_q),
    .valid_o  (quad_vld),
    .quad_o   (quad)
  );

  rsi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (quad_vld),
    .quad_i  (quad),
    .valid_o (root_vld),
    .root_o  (root)
  );

  rsi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (root_vld),
    .root_i  (root),
    .valid_o (res_vld),
    .res_o   (res)
  );

  assign out_valid_o  = res_vld;
  assign hit_o        = res.hit;
  assign far_param_o  = res.far_p;
  assign near_param_o = res.near_p;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (far_param_o == '0) && (near_param_o == '0))
    else $error("miss result with nonzero parameters");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (far_param_o >= near_param_o))
    else $error("far parameter below near parameter");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(root_vld) && $stable(quad_vld))
    else $error("pipeline moved during stall");

endmodule

// ----- dv/tb_ray_sphere_intersection_top.sv -----
// Testbench for ray_sphere_intersection_top: random and directed segment/sphere
// requests checked against an exact wide-integer predictor. Depends on rsi_pkg.
`timescale 1ns / 1ps
module tb_ray_sphere_intersection_top;
  import rsi_pkg::*;

  localparam int unsigned Latency = 105;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic   hit;
    coord_t far_p;
    coord_t near_p;
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t coord_in [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  coord_t far_param, near_param;

  logic [30:0] radius_q = 31'd65536;
  logic [31:0] limit_q = 32'd1;

  isect_t expected_q [$];
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cycles = 0;
  bit sink_bursts = 1'b1;
  bit src_bursts = 1'b1;

  always #2ns clk = ~clk;

  ray_sphere_intersection_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .start_x_i   (coord_in[0]),
    .start_y_i   (coord_in[1]),
    .start_z_i   (coord_in[2]),
    .end_x_i     (coord_in[3]),
    .end_y_i     (coord_in[4]),
    .end_z_i     (coord_in[5]),
    .centre_x_i  (coord_in[6]),
    .centre_y_i  (coord_in[7]),
    .centre_z_i  (coord_in[8]),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .hit_o       (hit),
    .far_param_o (far_param),
    .near_param_o(near_param)
  );

  initial for (int k = 0; k < 9; k++) coord_in[k] = '0;

  function automatic logic signed [255:0] isqrt_floor(logic signed [255:0] v);
    logic [255:0] r;
    logic [255:0] cand;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      cand = r | (256'd1 << i);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  function automatic coord_t scaled_quotient(logic signed [255:0] num,
                                             logic signed [255:0] den);
    logic signed [255:0] q;
    logic signed [255:0] mag;
    mag = num < 0 ? -num : num;
    q = (mag <<< FracW) / den;
    if (num < 0) q = -q;
    if (q > 256'sh7FFFFFFF) q = 256'sh7FFFFFFF;
    if (q < -256'sh80000000) q = -256'sh80000000;
    return q[CoordW-1:0];
  endfunction

  function automatic isect_t predict_isect(coord_t c [9]);
    logic signed [255:0] a, h, cc, d, e, disc, s, rr;
    isect_t r;
    a = 0; h = 0; cc = 0;
    for (int k = 0; k < 3; k++) begin
      d = 256'(signed'(c[3+k])) - 256'(signed'(c[k]));
      e = 256'(signed'(c[k])) - 256'(signed'(c[6+k]));
      a += d * d;
      h += d * e;
      cc += e * e;
    end
    rr = 256'(radius_q);
    cc -= rr * rr;
    disc = h * h - a * cc;
    r = '0;
    if (a == 0 || a < 256'(limit_q) || disc < 0) return r;
    s = isqrt_floor(disc);
    r.hit = 1'b1;
    r.far_p = scaled_quotient(-h + s, a);
    r.near_p = scaled_quotient(-h - s, a);
    return r;
  endfunction

  // result checker and sink stalls
  always @(posedge clk) begin
    isect_t got, want;
    if (out_valid && out_ready) begin
      got = '{hit, far_param, near_param};
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else if (sink_bursts && $urandom_range(0, 7) == 0) begin
      hold_cycles = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (expected_q.size() == 0 && !in_valid))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("** ray_sphere_intersection_top: FAILED **");
      $finish;
    end
  end

  task automatic send_request(coord_t c [9]);
    int unsigned gap;
    if (src_bursts && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    for (int k = 0; k < 9; k++) coord_in[k] <= c[k];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_isect(c));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == RegRadius) radius_q = val[30:0];
    else limit_q = val;
  endtask

  function automatic coord_t rand_coord(int unsigned span_sel);
    case (span_sel)
      0: return $urandom();
      1: return coord_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: return coord_t'($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                            : 32'sh8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_random(int unsigned n);
    coord_t c [9];
    int unsigned sel;
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      sel = sel < 5 ? 1 : (sel < 8 ? 2 : (sel < 9 ? 0 : 3));
      for (int k = 0; k < 9; k++) c[k] = rand_coord($urandom_range(0, 5) == 0 ? 0 : sel);
      if ($urandom_range(0, 19) == 0) for (int k = 0; k < 3; k++) c[3+k] = c[k];
      send_request(c);
    end
  endtask

  task automatic test_directed();
    coord_t c [9];
    // axis line through unit sphere
    c = '{-32'sh20000, 0, 0, 32'sh20000, 0, 0, 0, 0, 0};
    send_request(c);
    // tangent
    c = '{-32'sh20000, 32'sh10000, 0, 32'sh20000, 32'sh10000, 0, 0, 0, 0};
    send_request(c);
    // miss
    c = '{-32'sh20000, 32'sh30000, 0, 32'sh20000, 32'sh30000, 0, 0, 0, 0};
    send_request(c);
    // zero length
    c = '{5, 6, 7, 5, 6, 7, 0, 0, 0};
    send_request(c);
    // at the limit: length one lsb
    c = '{0, 0, 0, 1, 0, 0, 0, 0, 0};
    send_request(c);
    // extremes, some with saturating parameters
    c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0};
    send_request(c);
    c = '{32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFE, 0, 0, 32'sh8000_0000, 0, 0};
    send_request(c);
    c = '{0, 0, 0, 1, 1, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    send_request(c);
    c = '{-1, -1, -1, 0, 0, 0, -1, -1, -1};
    send_request(c);
    drain_results();
  endtask

  task automatic test_config_sweep();
    write_reg(RegRadius, 32'h7FFF_FFFF);
    write_reg(RegLimit, 32'hFFFF_FFFF);
    send_random(200);
    drain_results();
    write_reg(RegRadius, 32'd0);
    write_reg(RegLimit, 32'd0);
    send_random(200);
    drain_results();
    write_reg(RegRadius, $urandom_range(0, 32'h0010_0000));
    write_reg(RegLimit, $urandom_range(0, 32'h0001_0000));
    send_random(600);
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    send_random(200);
    drain_results();
  endtask

  task automatic test_final_burst();
    write_reg(RegRadius, 32'h0002_0000);
    write_reg(RegLimit, 32'd1);
    src_bursts = 1'b0;
    sink_bursts = 1'b0;
    send_random(600);
    drain_results();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_final_burst();
    if (n_errors == 0) $display("** ray_sphere_intersection_top: PASSED **");
    else $display("** ray_sphere_intersection_top: FAILED **");
    $finish;
  end

endmodule

// ----- ray_sphere_intersection_top.f -----
design/rsi_pkg.sv
design/rsi_quad.sv
design/rsi_sqrt.sv
design/rsi_div.sv
design/ray_sphere_intersection_top.sv
dv/tb_ray_sphere_intersection_top.sv
